// ===== sv/block_table_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// block_table_allocator_assert.svh
// Assertion macros shared by the allocator modules. The user must have
// signals named clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TABLE_ALLOCATOR_ASSERT_SVH
`define BLOCK_TABLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BTA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator check failed (same cycle)");

// next-cycle implication
`define BTA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator check failed (next cycle)");

`endif

// ===== sv/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Types, codes and defaults for the block table allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

   localparam int DEF_BLOCK_BYTES   = 32;
   localparam int DEF_TABLE_ENTRIES = 64;

   localparam int BYTES_W   = 16;
   localparam int OFFS_W    = 16;
   localparam int STATUS_W  = 2;
   localparam int AOFF_W    = 11;
   localparam int PCT_W     = 7;
   localparam int PCT_SCALE = 100;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FAIL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [BYTES_W-1:0] request_bytes;
      logic [OFFS_W-1:0]  free_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AOFF_W-1:0]   alloc_offset;
      logic [PCT_W-1:0]    used_percent;
   } rsp_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_NEED_DIV,
      S_SCAN,
      S_MARK,
      S_IDX_DIV,
      S_FREE_RD,
      S_FREE_LEN,
      S_CLR_RD,
      S_CLR_WR,
      S_PCT_DIV,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      DSEL_NEED,
      DSEL_IDX,
      DSEL_PCT
   } div_sel_type;

   typedef struct packed {
      logic                init_wr;
      logic                load_req;
      logic                div_start;
      div_sel_type         div_sel;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                set_aoff;
      logic                scan_start;
      logic                scan;
      logic                mark;
      logic                load_idx;
      logic                load_len;
      logic                clr_wr;
      logic                load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic op_free;
      logic bytes_zero;
      logic off_oob;
      logic div_done;
      logic need_big;
      logic scan_hit;
      logic scan_miss;
      logic mark_last;
      logic len_zero;
      logic clr_last;
      logic init_last;
   } ctl_stat_type;

endpackage

`default_nettype wire

// ===== sv/block_table_allocator.sv =====
// ----------------------------------------------------------------------------
// block_table_allocator
// Fixed-block pool allocator with one table entry per block.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken once the current one
// has reached the result register, which may still be waiting on rsp_ready.
// After reset the table RAM is cleared one entry per cycle, so req_ready
// stays low until every entry is cleared. Divisions (bytes to blocks, offset
// to block index, usage percent) share one reciprocal-multiply unit with a
// registered quotient. An allocation scans entries downward from the top
// entry, one per cycle through the RAM read port, and then marks the run it
// found; a failed scan reads every entry, while an oversize or zero-size
// request is failed without a scan. A free reads and then clears each entry
// of the run in turn through the single table RAM; an offset beyond the pool
// is refused before any table access. req_ready rises in the same cycle as
// rsp_valid, when the result is loaded; while the previous result is still
// waiting on rsp_ready, the load and req_ready are held off.
// ----------------------------------------------------------------------------
`default_nettype none

module block_table_allocator
   import bta_pkg::*;
#(
   parameter int BLOCK_BYTES   = DEF_BLOCK_BYTES,
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   ctl_cmd_type  ctl;
   ctl_stat_type sts;

   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   bta_datapath #(
      .BLOCK_BYTES   (BLOCK_BYTES),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/bta_ram.sv =====
// ----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/bta_div.sv =====
// ----------------------------------------------------------------------------
// bta_div
// Division by a constant through a rounded-up reciprocal. The dividend and
// reciprocal are latched on start, multiplied the next cycle, and the
// quotient is registered and valid on the done pulse, held until the next
// start.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_table_allocator_assert.svh"

module bta_div #(
   parameter int DIV_W = 17,
   parameter int REC_W = 25,
   parameter int SHIFT = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [REC_W-1:0] recip,
   output      logic [DIV_W-1:0] quotient,
   output      logic             done
);

   localparam int PROD_W = DIV_W + REC_W;

   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [REC_W-1:0]  rec_ff, rec_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] product;

   // reciprocal carries SHIFT fraction bits; exact for every dividend below 2**DIV_W
   always_comb begin
      dvd_in  = dvd_ff;
      rec_in  = rec_ff;
      quo_in  = quo_ff;
      busy_in = start;
      done_in = busy_ff;
      product = PROD_W'(dvd_ff) * PROD_W'(rec_ff);
      if (start) begin
         dvd_in = dividend;
         rec_in = recip;
      end
      if (busy_ff) begin
         quo_in = product[SHIFT +: DIV_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rec_ff <= rec_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

   `BTA_ASSERT_NXT(a_start_busy, start, busy_ff)
   `BTA_ASSERT_NXT(a_busy_done, busy_ff, done_ff)
   `BTA_ASSERT_IMP(a_no_start_busy, busy_ff, !start)

endmodule

`default_nettype wire

// ===== sv/bta_datapath.sv =====
// ----------------------------------------------------------------------------
// bta_datapath
// Block table RAM, scan/mark/clear pointers, usage count, shared divider
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_table_allocator_assert.svh"

module bta_datapath
   import bta_pkg::*;
#(
   parameter int BLOCK_BYTES   = DEF_BLOCK_BYTES,
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_data,
   input  wire ctl_cmd_type  ctl,
   output      ctl_stat_type sts,
   output      rsp_type      rsp_data
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int ENT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
   localparam int SOR_W   = (BLOCK_BYTES > TABLE_ENTRIES) ? BB_W : ENT_W;
   localparam int NEED_DW = $clog2((2 ** BYTES_W) - 1 + BLOCK_BYTES);
   localparam int PCT_DW  = $clog2(TABLE_ENTRIES * PCT_SCALE + 1);
   localparam int DIV_W   = (NEED_DW > PCT_DW) ? NEED_DW : PCT_DW;
   localparam int POOL    = TABLE_ENTRIES * BLOCK_BYTES;
   localparam int POOL_W  = $clog2(POOL + 1);
   localparam int CMP_W   = (POOL_W > OFFS_W) ? POOL_W : OFFS_W;
   localparam int OFF_W   = (IDX_W + BB_W > AOFF_W) ? IDX_W + BB_W : AOFF_W;
   localparam int REC_SH  = DIV_W + SOR_W;
   localparam int REC_W   = REC_SH + 1;

   // rounded-up reciprocals of the two divisors
   localparam logic [REC_W-1:0] REC_BLOCK =
      REC_W'(((64'd1 << REC_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
   localparam logic [REC_W-1:0] REC_TABLE =
      REC_W'(((64'd1 << REC_SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

   // latched request
   logic               op_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [OFFS_W-1:0]  offs_ff;

   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic                issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [ENT_W-1:0]    run_ff, run_in;
   logic [ENT_W-1:0]    need_ff, need_in;
   logic [ENT_W-1:0]    cnt_ff, cnt_in;
   logic [ENT_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    base_ff, base_in;
   logic [ENT_W-1:0]    used_ff, used_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [AOFF_W-1:0]   aoff_ff, aoff_in;
   rsp_type             rsp_ff, rsp_in;

   logic             wr_en;
   logic [ENT_W-1:0] wr_data;
   logic [ENT_W-1:0] rd_data;

   logic [DIV_W-1:0] dividend;
   logic [REC_W-1:0] recip;
   logic [DIV_W-1:0] quotient;
   logic             div_done;

   logic [ENT_W-1:0] run_inc;
   logic             rd_free;
   logic             hit;
   logic [OFF_W-1:0] off_full;

   bta_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   bta_div #(
      .DIV_W (DIV_W),
      .REC_W (REC_W),
      .SHIFT (REC_SH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (dividend),
      .recip    (recip),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      run_inc  = run_ff + ENT_W'(1);
      rd_free  = (rd_data == '0);
      hit      = rd_vld_ff && rd_free && (run_inc == need_ff);
      off_full = OFF_W'(base_ff) * OFF_W'(BLOCK_BYTES);

      sts.op_free    = (op_ff == CMD_FREE);
      sts.bytes_zero = (bytes_ff == '0);
      sts.off_oob    = (CMP_W'(offs_ff) >= CMP_W'(POOL));
      sts.div_done   = div_done;
      sts.need_big   = (quotient > DIV_W'(TABLE_ENTRIES));
      sts.scan_hit   = hit;
      sts.scan_miss  = rd_vld_ff && !hit && (rd_idx_ff == '0);
      sts.mark_last  = (cnt_ff == need_ff - ENT_W'(1));
      sts.len_zero   = rd_free;
      // a run is cleared no further than the top entry
      sts.clr_last   = (cnt_ff == len_ff - ENT_W'(1)) ||
                       (ptr_ff == IDX_W'(TABLE_ENTRIES - 1));
      sts.init_last  = (ptr_ff == IDX_W'(TABLE_ENTRIES - 1));
   end

   // usage count follows every table write
   always_comb begin
      used_in = used_ff;
      if (ctl.mark) begin
         used_in = used_ff + ENT_W'(1);
      end else if (ctl.clr_wr && !rd_free) begin
         used_in = used_ff - ENT_W'(1);
      end
   end

   always_comb begin
      case (ctl.div_sel)
         DSEL_NEED: begin
            dividend = DIV_W'(bytes_ff) + DIV_W'(BLOCK_BYTES - 1);
            recip    = REC_BLOCK;
         end
         DSEL_IDX: begin
            dividend = DIV_W'(offs_ff);
            recip    = REC_BLOCK;
         end
         DSEL_PCT: begin
            dividend = DIV_W'(used_in) * DIV_W'(PCT_SCALE);
            recip    = REC_TABLE;
         end
         default: begin
            dividend = DIV_W'(used_in) * DIV_W'(PCT_SCALE);
            recip    = REC_TABLE;
         end
      endcase
   end

   always_comb begin
      wr_en   = ctl.init_wr || ctl.mark || ctl.clr_wr;
      wr_data = ctl.mark ? need_ff : '0;
   end

   always_comb begin
      ptr_in    = ptr_ff;
      issue_in  = issue_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      run_in    = run_ff;
      need_in   = need_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      base_in   = base_ff;
      status_in = status_ff;
      aoff_in   = aoff_ff;
      rsp_in    = rsp_ff;

      if (ctl.init_wr || ctl.mark || ctl.clr_wr) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end
      if (ctl.mark || ctl.clr_wr) begin
         cnt_in = cnt_ff + ENT_W'(1);
      end

      if (ctl.scan_start) begin
         ptr_in   = IDX_W'(TABLE_ENTRIES - 1);
         issue_in = 1'b1;
         run_in   = '0;
         cnt_in   = '0;
         need_in  = quotient[ENT_W-1:0];
      end

      // scan: one read issued per beat, checked a beat later
      if (ctl.scan) begin
         if (issue_ff) begin
            ptr_in    = ptr_ff - IDX_W'(1);
            issue_in  = (ptr_ff != '0);
            rd_vld_in = 1'b1;
            rd_idx_in = ptr_ff;
         end
         if (rd_vld_ff) begin
            run_in = rd_free ? run_inc : '0;
         end
         if (hit) begin
            ptr_in    = rd_idx_ff;
            base_in   = rd_idx_ff;
            rd_vld_in = 1'b0;
         end
      end

      if (ctl.load_idx) begin
         ptr_in = quotient[IDX_W-1:0];
      end
      if (ctl.load_len) begin
         len_in = rd_data;
         cnt_in = '0;
      end
      if (ctl.set_status) begin
         status_in = ctl.status_code;
      end
      if (ctl.load_req) begin
         aoff_in = '0;
      end
      if (ctl.set_aoff) begin
         aoff_in = off_full[AOFF_W-1:0];
      end
      if (ctl.load_rsp) begin
         rsp_in.status       = status_ff;
         rsp_in.alloc_offset = aoff_ff;
         rsp_in.used_percent = quotient[PCT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
         used_ff   <= '0;
      end else begin
         ptr_ff    <= ptr_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= rd_vld_in;
         used_ff   <= used_in;
      end
      if (ctl.load_req) begin
         op_ff    <= req_data.cmd;
         bytes_ff <= req_data.request_bytes;
         offs_ff  <= req_data.free_offset;
      end
      rd_idx_ff <= rd_idx_in;
      run_ff    <= run_in;
      need_ff   <= need_in;
      cnt_ff    <= cnt_in;
      len_ff    <= len_in;
      base_ff   <= base_in;
      status_ff <= status_in;
      aoff_ff   <= aoff_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `BTA_ASSERT_IMP(a_mark_within_run, ctl.mark, cnt_ff < need_ff)
   `BTA_ASSERT_IMP(a_mark_need_nonzero, ctl.mark, need_ff != '0)
   `BTA_ASSERT_IMP(a_used_no_underflow, ctl.clr_wr && !rd_free, used_ff != '0)

endmodule

`default_nettype wire

// ===== sv/bta_ctrl.sv =====
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer for the allocator: table clear after reset, decode, divide,
// scan, mark, clear and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_table_allocator_assert.svh"

module bta_ctrl
   import bta_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   output      ctl_cmd_type  ctl,
   input  wire ctl_stat_type sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      div_wait;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      ctl             = '0;
      ctl.div_sel     = DSEL_PCT;
      ctl.status_code = STAT_OK;
      req_ready       = 1'b0;

      case (state_ff)
         S_INIT: begin
            ctl.init_wr = 1'b1;
            if (sts.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.div_start = 1'b1;
            if (!sts.op_free) begin
               if (sts.bytes_zero) begin
                  ctl.set_status  = 1'b1;
                  ctl.status_code = STAT_FAIL;
                  state_in        = S_PCT_DIV;
               end else begin
                  ctl.div_sel = DSEL_NEED;
                  state_in    = S_NEED_DIV;
               end
            end else begin
               if (sts.off_oob) begin
                  ctl.set_status  = 1'b1;
                  ctl.status_code = STAT_RANGE;
                  state_in        = S_PCT_DIV;
               end else begin
                  ctl.div_sel = DSEL_IDX;
                  state_in    = S_IDX_DIV;
               end
            end
         end
         S_NEED_DIV: begin
            if (sts.div_done) begin
               if (sts.need_big) begin
                  ctl.set_status  = 1'b1;
                  ctl.status_code = STAT_FAIL;
                  ctl.div_start   = 1'b1;
                  state_in        = S_PCT_DIV;
               end else begin
                  ctl.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_hit) begin
               state_in = S_MARK;
            end else if (sts.scan_miss) begin
               ctl.set_status  = 1'b1;
               ctl.status_code = STAT_FAIL;
               ctl.div_start   = 1'b1;
               state_in        = S_PCT_DIV;
            end
         end
         S_MARK: begin
            ctl.mark = 1'b1;
            if (sts.mark_last) begin
               ctl.set_status  = 1'b1;
               ctl.status_code = STAT_OK;
               ctl.set_aoff    = 1'b1;
               ctl.div_start   = 1'b1;
               state_in        = S_PCT_DIV;
            end
         end
         S_IDX_DIV: begin
            if (sts.div_done) begin
               ctl.load_idx = 1'b1;
               state_in     = S_FREE_RD;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_LEN;
         end
         S_FREE_LEN: begin
            if (sts.len_zero) begin
               // block already free: nothing to clear
               ctl.set_status  = 1'b1;
               ctl.status_code = STAT_OK;
               ctl.div_start   = 1'b1;
               state_in        = S_PCT_DIV;
            end else begin
               ctl.load_len = 1'b1;
               state_in     = S_CLR_RD;
            end
         end
         S_CLR_RD: begin
            state_in = S_CLR_WR;
         end
         S_CLR_WR: begin
            ctl.clr_wr = 1'b1;
            if (sts.clr_last) begin
               ctl.set_status  = 1'b1;
               ctl.status_code = STAT_OK;
               ctl.div_start   = 1'b1;
               state_in        = S_PCT_DIV;
            end else begin
               state_in = S_CLR_RD;
            end
         end
         S_PCT_DIV: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign div_wait = (state_ff == S_NEED_DIV) || (state_ff == S_IDX_DIV) ||
                     (state_ff == S_PCT_DIV);

   `BTA_ASSERT_NXT(a_accept_decodes, req_valid && req_ready, state_ff == S_DECODE)
   `BTA_ASSERT_IMP(a_div_done_expected, sts.div_done, div_wait)
   `BTA_ASSERT_IMP(a_ready_only_idle, req_ready, state_ff == S_IDLE)

endmodule

`default_nettype wire
